// ===== rtl/qrs_pkg.sv =====
// Shared constants, types and helpers for the quadratic root solver.
// Used by every module under rtl/; depends on nothing else.
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 33;

  localparam int PROD_W     = 2 * COEF_WIDTH;
  localparam int DELTA_W    = 2 * COEF_WIDTH + 2;
  localparam int SQRT_STEPS = DELTA_W / 2 + FRAC_BITS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NUM_MAG_W  = ROOT_W + 1;
  localparam int NUM_S_W    = NUM_MAG_W + 1;
  localparam int DEN_W      = COEF_WIDTH + 1;

  localparam logic [NUM_MAG_W-1:0] SAT_LIM = NUM_MAG_W'(1) << (OUT_W - 1);

  typedef enum logic [1:0] {
    ST_NOT_QUAD = 2'd0,
    ST_NO_ROOT  = 2'd1,
    ST_ONE_ROOT = 2'd2,
    ST_TWO_ROOT = 2'd3
  } status_t;

  // Sideband that rides alongside the square-root pipe
  typedef struct packed {
    status_t                    status;
    logic signed [NUM_S_W-1:0]  base;
    logic                       den_neg;
    logic [DEN_W-1:0]           den_mag;
  } side_t;

  // One division lane: partial remainder, numerator/quotient shifter, result sign
  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [NUM_MAG_W-1:0] nq;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    status_t          status;
    logic [DEN_W-1:0] den_mag;
  } dside_t;

  // Apply the sign to a quotient magnitude and clamp to the output range
  function automatic logic signed [OUT_W-1:0] sat_root(input logic [NUM_MAG_W-1:0] q,
                                                       input logic neg);
    logic [NUM_MAG_W-1:0]    q_neg;
    logic signed [OUT_W-1:0] res;
    q_neg = NUM_MAG_W'(~q + NUM_MAG_W'(1));
    if (neg) begin
      if (q > SAT_LIM) res = {1'b1, {(OUT_W-1){1'b0}}};
      else             res = q_neg[OUT_W-1:0];
    end else begin
      if (q >= SAT_LIM) res = {1'b0, {(OUT_W-1){1'b1}}};
      else              res = q[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/quadratic_root_solver_top.sv =====
// Top level of the quadratic real-root solver.
// Depends on qrs_pkg, qrs_sqrt_pipe and qrs_div_pipe.
//
// Usage:
//   Input channel in_valid / in_stall carries signed coefficients a, b, c.
//   Result channel out_valid / out_stall carries a status and two signed
//   Q16.16 roots (33 bits). A transaction completes on a rising edge with
//   valid high and stall low.
// Pipeline: 71 register stages from input to out_*: one multiply stage, one
//   discriminant stage, 33 square-root stages (one bit pair each), one
//   numerator stage, 34 divider stages (one quotient bit each) and the
//   output register.
// Throughput: one transaction per cycle when not stalled; every stage is
//   registered and the whole pipeline moves together.
// Stall: while the output register holds an untaken result and out_stall
//   is high, the whole pipeline freezes, bubbles included, and in_stall is
//   raised; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits; the data
//   registers have no reset and there is no clearing pass.
module quadratic_root_solver_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]    in_coef_a,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]    in_coef_b,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]    in_coef_c,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [1:0]                               out_status,
  output logic signed [qrs_pkg::OUT_W-1:0]         out_root_plus,
  output logic signed [qrs_pkg::OUT_W-1:0]         out_root_minus
);

  logic en;

  // Advance whenever the output register is empty or being taken
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: products b*b and a*c
  logic                                  s1_vld_r;
  logic signed [qrs_pkg::COEF_WIDTH-1:0] s1_a_r, s1_b_r;
  logic signed [qrs_pkg::PROD_W-1:0]     s1_bb_r, s1_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= in_coef_a;
      s1_b_r  <= in_coef_b;
      s1_bb_r <= in_coef_b * in_coef_b;
      s1_ac_r <= in_coef_a * in_coef_c;
    end
  end

  // Stage 2: discriminant, status, numerator base and divisor magnitude
  logic signed [qrs_pkg::DELTA_W-1:0] delta;
  logic signed [qrs_pkg::DEN_W-1:0]   a_ext, a_abs;
  qrs_pkg::side_t                     side_nxt;
  logic [qrs_pkg::DELTA_W-1:0]        d_nxt;
  logic                               s2_vld_r;
  logic [qrs_pkg::DELTA_W-1:0]        s2_d_r;
  qrs_pkg::side_t                     s2_side_r;

  always_comb begin
    delta = qrs_pkg::DELTA_W'(s1_bb_r) - (qrs_pkg::DELTA_W'(s1_ac_r) <<< 2);
    a_ext = qrs_pkg::DEN_W'(s1_a_r);
    a_abs = a_ext[qrs_pkg::DEN_W-1] ? -a_ext : a_ext;
    priority if (s1_a_r == '0)                 side_nxt.status = qrs_pkg::ST_NOT_QUAD;
    else if (delta[qrs_pkg::DELTA_W-1])        side_nxt.status = qrs_pkg::ST_NO_ROOT;
    else if (delta == '0)                      side_nxt.status = qrs_pkg::ST_ONE_ROOT;
    else                                       side_nxt.status = qrs_pkg::ST_TWO_ROOT;
    side_nxt.base    = -(qrs_pkg::NUM_S_W'(s1_b_r) <<< qrs_pkg::FRAC_BITS);
    side_nxt.den_neg = s1_a_r[qrs_pkg::COEF_WIDTH-1];
    side_nxt.den_mag = {a_abs[qrs_pkg::DEN_W-2:0], 1'b0};
    // Negative discriminant never reaches the roots; feed zero to the root
    d_nxt = delta[qrs_pkg::DELTA_W-1] ? '0 : delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r    <= d_nxt;
      s2_side_r <= side_nxt;
    end
  end

  // Square root of the scaled discriminant
  logic                       sq_vld;
  logic [qrs_pkg::ROOT_W-1:0] sq_root;
  qrs_pkg::side_t             sq_side;

  qrs_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_d     (s2_d_r),
    .in_side  (s2_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Both roots divided by 2a, truncated toward zero
  logic             dv_vld;
  qrs_pkg::status_t dv_status;
  qrs_pkg::lane_t   dv_lane_p, dv_lane_m;

  qrs_div_pipe u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (sq_vld),
    .in_root    (sq_root),
    .in_side    (sq_side),
    .out_vld    (dv_vld),
    .out_status (dv_status),
    .out_lane_p (dv_lane_p),
    .out_lane_m (dv_lane_m)
  );

  // Output register: sign, clamp, and zero the roots when there are none
  logic                            has_root;
  logic signed [qrs_pkg::OUT_W-1:0] rp_nxt, rm_nxt;
  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic signed [qrs_pkg::OUT_W-1:0] out_rp_r, out_rm_r;

  always_comb begin
    has_root = (dv_status == qrs_pkg::ST_ONE_ROOT) || (dv_status == qrs_pkg::ST_TWO_ROOT);
    rp_nxt   = has_root ? qrs_pkg::sat_root(dv_lane_p.nq, dv_lane_p.neg) : '0;
    rm_nxt   = has_root ? qrs_pkg::sat_root(dv_lane_m.nq, dv_lane_m.neg) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= dv_status;
      out_rp_r     <= rp_nxt;
      out_rm_r     <= rm_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_root_plus  = out_rp_r;
  assign out_root_minus = out_rm_r;

  // A result with no real root carries zero roots
  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qrs_pkg::ST_NOT_QUAD || out_status == qrs_pkg::ST_NO_ROOT)
    |-> (out_root_plus == '0) && (out_root_minus == '0))
    else $error("roots not zero without real root");

  // A single root appears on both root fields
  a_one_root_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qrs_pkg::ST_ONE_ROOT) |-> (out_root_plus == out_root_minus))
    else $error("single root differs between fields");

  // A held result back-pressures the input side
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result held");

  // A stalled result stays put until it is taken
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_root_plus) && $stable(out_root_minus))
    else $error("stalled result changed");

endmodule

// ===== rtl/qrs_sqrt_pipe.sv =====
// Pipelined bit-pair integer square root of delta * 2^(2*FRAC_BITS), one pair per stage.
// Depends on qrs_pkg.
module qrs_sqrt_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [qrs_pkg::DELTA_W-1:0] in_d,
  input  qrs_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [qrs_pkg::ROOT_W-1:0]  out_root,
  output qrs_pkg::side_t              out_side
);

  logic                        vld_r  [qrs_pkg::SQRT_STEPS];
  logic [qrs_pkg::DELTA_W-1:0] d_r    [qrs_pkg::SQRT_STEPS];
  logic [qrs_pkg::REM_W-1:0]   rem_r  [qrs_pkg::SQRT_STEPS];
  logic [qrs_pkg::ROOT_W-1:0]  root_r [qrs_pkg::SQRT_STEPS];
  qrs_pkg::side_t              side_r [qrs_pkg::SQRT_STEPS];

  for (genvar k = 0; k < qrs_pkg::SQRT_STEPS; k++) begin : g_step
    localparam int PI = qrs_pkg::SQRT_STEPS - 1 - k;
    logic                        vld_in;
    logic [qrs_pkg::DELTA_W-1:0] d_in;
    logic [qrs_pkg::REM_W-1:0]   rem_in;
    logic [qrs_pkg::ROOT_W-1:0]  root_in;
    qrs_pkg::side_t              side_in;
    logic [1:0]                  pair;
    logic [qrs_pkg::REM_W-1:0]   rem2;
    logic [qrs_pkg::REM_W-1:0]   trial;
    logic [qrs_pkg::REM_W-1:0]   rem_nxt;
    logic [qrs_pkg::ROOT_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign d_in    = in_d;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign d_in    = d_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Low pairs are the zero fraction bits appended by the scaling
    if (PI >= qrs_pkg::FRAC_BITS) begin : g_pair
      assign pair = d_in[2*(PI-qrs_pkg::FRAC_BITS) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem2  = {rem_in[qrs_pkg::REM_W-3:0], pair};
      trial = {root_in, 2'b01};
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {root_in[qrs_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {root_in[qrs_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k]    <= d_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[qrs_pkg::SQRT_STEPS-1];
  assign out_root = root_r[qrs_pkg::SQRT_STEPS-1];
  assign out_side = side_r[qrs_pkg::SQRT_STEPS-1];

endmodule

// ===== rtl/qrs_div_pipe.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, after a prep stage.
// Depends on qrs_pkg.
module qrs_div_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [qrs_pkg::ROOT_W-1:0] in_root,
  input  qrs_pkg::side_t             in_side,
  output logic                       out_vld,
  output qrs_pkg::status_t           out_status,
  output qrs_pkg::lane_t             out_lane_p,
  output qrs_pkg::lane_t             out_lane_m
);

  localparam int N = qrs_pkg::NUM_MAG_W;

  logic signed [qrs_pkg::NUM_S_W-1:0] num_p, num_m, s_ext;
  logic [qrs_pkg::NUM_S_W-1:0]        mag_p, mag_m;
  qrs_pkg::lane_t                     lane_p_nxt, lane_m_nxt;
  logic                               prep_vld_r;
  qrs_pkg::lane_t                     prep_p_r, prep_m_r;
  qrs_pkg::dside_t                    prep_side_r;

  // Form both numerators and take magnitudes
  always_comb begin
    s_ext = qrs_pkg::NUM_S_W'(in_root);
    num_p = in_side.base + s_ext;
    num_m = in_side.base - s_ext;
    mag_p = num_p[qrs_pkg::NUM_S_W-1] ? -num_p : num_p;
    mag_m = num_m[qrs_pkg::NUM_S_W-1] ? -num_m : num_m;
    lane_p_nxt.rem = '0;
    lane_p_nxt.nq  = mag_p[N-1:0];
    lane_p_nxt.neg = num_p[qrs_pkg::NUM_S_W-1] ^ in_side.den_neg;
    lane_m_nxt.rem = '0;
    lane_m_nxt.nq  = mag_m[N-1:0];
    lane_m_nxt.neg = num_m[qrs_pkg::NUM_S_W-1] ^ in_side.den_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_p_r            <= lane_p_nxt;
      prep_m_r            <= lane_m_nxt;
      prep_side_r.status  <= in_side.status;
      prep_side_r.den_mag <= in_side.den_mag;
    end
  end

  logic            vld_r  [N];
  qrs_pkg::lane_t  lane_r [N][2];
  qrs_pkg::dside_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic            vld_in;
    qrs_pkg::dside_t side_in;
    qrs_pkg::lane_t  lin  [2];
    qrs_pkg::lane_t  lnxt [2];

    if (k == 0) begin : g_first
      assign vld_in  = prep_vld_r;
      assign side_in = prep_side_r;
      assign lin[0]  = prep_p_r;
      assign lin[1]  = prep_m_r;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign side_in = side_r[k-1];
      assign lin[0]  = lane_r[k-1][0];
      assign lin[1]  = lane_r[k-1][1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [qrs_pkg::DEN_W:0] rem2, diff;
      logic                    ge;
      always_comb begin
        rem2 = {lin[l].rem, lin[l].nq[N-1]};
        diff = rem2 - {1'b0, side_in.den_mag};
        ge   = rem2 >= {1'b0, side_in.den_mag};
        lnxt[l].rem = ge ? diff[qrs_pkg::DEN_W-1:0] : rem2[qrs_pkg::DEN_W-1:0];
        lnxt[l].nq  = {lin[l].nq[N-2:0], ge};
        lnxt[l].neg = lin[l].neg;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k]    <= side_in;
        lane_r[k][0] <= lnxt[0];
        lane_r[k][1] <= lnxt[1];
      end
    end
  end

  assign out_vld    = vld_r[N-1];
  assign out_status = side_r[N-1].status;
  assign out_lane_p = lane_r[N-1][0];
  assign out_lane_m = lane_r[N-1][1];

endmodule
